[rtl/bounded_undo_redo_history_defines.svh]
// Assertion macros for the undo/redo history block.
`ifndef BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH
`define BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH

`ifndef SYNTHESIS

`define BURH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define BURH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BURH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BURH_ASSERT_ALWAYS(label, cond, msg)

`define BURH_ASSERT_IMP(label, ante, cons, msg)

`define BURH_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/burh_pkg.sv]
// Shared constants, types and helpers of the undo/redo history block.
package burh_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int STATE_BITS    = 64;

    localparam int REQ_W   = 2;
    localparam int WORD_W  = 64;
    localparam int DEPTH_W = 6;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

    typedef logic [STATE_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = REQ_W'(0),
        REQ_UNDO = REQ_W'(1),
        REQ_REDO = REQ_W'(2)
    } t_req;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_IN,
        SH_OUT
    } t_shift;

    function automatic logic [DEPTH_W-1:0] to_depth(input t_cnt c);
        logic [CNT_W+DEPTH_W-1:0] wide;
        wide = {{DEPTH_W{1'b0}}, c};
        return wide[DEPTH_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_field(input t_word w);
        logic [STATE_BITS+WORD_W-1:0] wide;
        wide = {{WORD_W{1'b0}}, w};
        return wide[WORD_W-1:0];
    endfunction

    function automatic t_word from_field(input logic [WORD_W-1:0] f);
        logic [STATE_BITS+WORD_W-1:0] wide;
        wide = {{STATE_BITS{1'b0}}, f};
        return wide[STATE_BITS-1:0];
    endfunction

endpackage

[rtl/burh_req_if.sv]
// Request channel: request code and caller state word.
interface burh_req_if import burh_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [WORD_W-1:0]  current_state;

    modport source (output valid, output req_type, output current_state, input ready);
    modport sink   (input valid, input req_type, input current_state, output ready);

endinterface

[rtl/burh_rsp_if.sv]
// Response channel: status, restored word and history depths.
interface burh_rsp_if import burh_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               ok;
    logic [WORD_W-1:0]  restored_state;
    logic [DEPTH_W-1:0] undo_depth;
    logic [DEPTH_W-1:0] redo_depth;

    modport source (output valid, output ok, output restored_state, output undo_depth,
                    output redo_depth, input ready);
    modport sink   (input valid, input ok, input restored_state, input undo_depth,
                    input redo_depth, output ready);

endinterface

[rtl/burh_cell.sv]
// One stack cell: holds a word, loads from either neighbor.
module burh_cell import burh_pkg::*; (
    input  logic   i_clk,
    input  t_shift i_op,
    input  t_word  i_prev,
    input  t_word  i_next,
    output t_word  o_word
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            SH_IN:   r_word <= i_prev;
            SH_OUT:  r_word <= i_next;
            default: r_word <= r_word;
        endcase
    end

    assign o_word = r_word;

endmodule

[rtl/burh_stack.sv]
// Row of cells forming a shift stack, newest word in cell zero.
module burh_stack import burh_pkg::*; (
    input  logic   i_clk,
    input  t_shift i_op,
    input  t_word  i_word,
    output t_word  o_top
);

    t_word w_cell [HISTORY_DEPTH];

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        t_word w_prev;
        t_word w_next;

        if (k == 0) begin : g_first
            assign w_prev = i_word;
        end else begin : g_mid
            assign w_prev = w_cell[k-1];
        end

        if (k == HISTORY_DEPTH - 1) begin : g_last
            assign w_next = w_cell[k];
        end else begin : g_body
            assign w_next = w_cell[k+1];
        end

        burh_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (i_op),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_word (w_cell[k])
        );
    end

    assign o_top = w_cell[0];

endmodule

[rtl/bounded_undo_redo_history.sv]
// Top level of the bounded undo/redo history.
//
//   channel  dir  payload                                          beat when
//   i_req    in   req_type, current_state                          valid & ready
//   o_rsp    out  ok, restored_state, undo_depth, redo_depth       valid & ready
//
// One request per cycle unless o_rsp stalls; the response is valid the next cycle.
// Undo and redo sides are two shift stacks of cells; every request shifts each
// by at most one place, so the counters and stack tops settle in the next cycle.
// Reset clears both depths and the response valid flag; cell contents are kept.
// A stalled response holds; a new request is taken in the cycle it drains.
module bounded_undo_redo_history import burh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    burh_req_if.sink   i_req,
    burh_rsp_if.source o_rsp
);

    `include "bounded_undo_redo_history_defines.svh"

    localparam int SUM_W = CNT_W + 1;

    t_cnt   r_undo_cnt, n_undo_cnt;
    t_cnt   r_redo_cnt, n_redo_cnt;
    logic   r_valid;
    logic   r_ok, n_ok;
    t_word  r_restored, n_restored;
    t_shift w_undo_op, w_redo_op;
    t_word  w_word, w_undo_top, w_redo_top;
    logic   w_accept;
    logic   w_full;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_word      = from_field(i_req.current_state);
    assign w_full      = (r_undo_cnt == CNT_W'(HISTORY_DEPTH));

    always_comb begin
        n_undo_cnt = r_undo_cnt;
        n_redo_cnt = r_redo_cnt;
        n_ok       = 1'b0;
        n_restored = '0;
        w_undo_op  = SH_HOLD;
        w_redo_op  = SH_HOLD;
        unique case (i_req.req_type)
            REQ_PUSH: begin
                n_ok       = 1'b1;
                n_redo_cnt = '0;
                w_undo_op  = SH_IN;
                if (!w_full) begin
                    n_undo_cnt = r_undo_cnt + t_cnt'(1);
                end
            end
            REQ_UNDO: begin
                if (r_undo_cnt != '0) begin
                    n_ok       = 1'b1;
                    n_restored = w_undo_top;
                    n_undo_cnt = r_undo_cnt - t_cnt'(1);
                    n_redo_cnt = r_redo_cnt + t_cnt'(1);
                    w_undo_op  = SH_OUT;
                    w_redo_op  = SH_IN;
                end
            end
            REQ_REDO: begin
                if (r_redo_cnt != '0) begin
                    n_ok       = 1'b1;
                    n_restored = w_redo_top;
                    n_redo_cnt = r_redo_cnt - t_cnt'(1);
                    n_undo_cnt = r_undo_cnt + t_cnt'(1);
                    w_redo_op  = SH_OUT;
                    w_undo_op  = SH_IN;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (!w_accept) begin
            w_undo_op = SH_HOLD;
            w_redo_op = SH_HOLD;
        end
    end

    burh_stack u_undo (
        .i_clk  (i_clk),
        .i_op   (w_undo_op),
        .i_word (w_word),
        .o_top  (w_undo_top)
    );

    burh_stack u_redo (
        .i_clk  (i_clk),
        .i_op   (w_redo_op),
        .i_word (w_word),
        .o_top  (w_redo_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undo_cnt <= '0;
            r_redo_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_undo_cnt <= n_undo_cnt;
                r_redo_cnt <= n_redo_cnt;
                r_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok       <= n_ok;
            r_restored <= n_restored;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.ok             = r_ok;
    assign o_rsp.restored_state = to_field(r_restored);
    assign o_rsp.undo_depth     = to_depth(r_undo_cnt);
    assign o_rsp.redo_depth     = to_depth(r_redo_cnt);

    `BURH_ASSERT_ALWAYS(a_depth_bound,
        ({1'b0, r_undo_cnt} + {1'b0, r_redo_cnt}) <= SUM_W'(HISTORY_DEPTH),
        "undo plus redo exceeds history depth")
    `BURH_ASSERT_NEXT(a_push_clears_redo,
        w_accept && i_req.req_type == REQ_PUSH,
        r_redo_cnt == '0,
        "push left redo entries")
    `BURH_ASSERT_NEXT(a_undo_moves_entry,
        w_accept && i_req.req_type == REQ_UNDO && r_undo_cnt != '0,
        (r_undo_cnt + t_cnt'(1) == $past(r_undo_cnt)) &&
        (r_redo_cnt == $past(r_redo_cnt) + t_cnt'(1)),
        "undo did not move one entry to redo side")
    `BURH_ASSERT_IMP(a_fail_zero_word,
        r_valid && !r_ok,
        r_restored == '0,
        "failed request returned a word")

endmodule
